>>> rtl/npfs_pkg.sv
package npfs_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int COORD_W = 16;
  localparam int FACE_W  = 3;
  localparam int IDX_W   = 9;
  localparam int DIST_W  = 33;
  localparam int COUNT_W = 10;

  typedef struct packed {
    logic               cmd;
    logic [IDX_W-1:0]   entry_index;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [FACE_W-1:0]  face_tag;
  } npfs_item_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] nearest_dist_sq;
  } npfs_result_t;

  // one table entry as stored in the point memory
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [FACE_W-1:0]  face;
  } npfs_point_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [FACE_W-1:0]  face_tag;
  } npfs_query_t;

endpackage

>>> rtl/nearest_point_on_face_search.sv
// Write item: accepted while idle, no result; ready stays high.
// Query item: the result follows a scan of the first active_points table entries
// (the scanned count saturates at MAX_POINTS; one table entry read per cycle, then 3 stages
// of diff/square/compare and the result register). One item in flight at a time: the
// next item can be accepted in the same cycle that result_valid rises, later if the result waits.
// Sync reset clears control state and active_points; the point table is not cleared.
module nearest_point_on_face_search
  import npfs_pkg::*;
#(
  parameter int MAX_POINTS = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata,
  input  logic                item_valid,
  output logic                item_ready,
  input  npfs_item_t          item,
  output logic                result_valid,
  input  logic                result_ready,
  output npfs_result_t        result
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {T_IDLE, T_BUSY, T_HOLD} state_t;

  state_t         state;
  logic [COUNT_W-1:0] active_points;
  logic [CW-1:0]  count;
  logic           accept;
  logic           ram_we;
  logic           scan_start;
  logic           scan_rd_en;
  logic [AW-1:0]  scan_rd_addr;
  npfs_point_t    rd_data;
  npfs_point_t    wr_point;
  npfs_query_t    query;
  logic           scan_done;
  npfs_result_t   scan_result;
  logic           out_free;
  logic           out_load;

  assign item_ready = (state == T_IDLE);
  assign accept     = item_valid && item_ready;
  assign ram_we     = accept && (item.cmd == CMD_WRITE)
                      && (32'(item.entry_index) < 32'(MAX_POINTS));
  assign scan_start = accept && (item.cmd == CMD_QUERY);
  assign out_free   = !result_valid || result_ready;
  assign out_load   = out_free && (((state == T_BUSY) && scan_done) || (state == T_HOLD));

  assign count = (32'(active_points) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                       : CW'(active_points);

  assign wr_point.x    = item.pos_x;
  assign wr_point.y    = item.pos_y;
  assign wr_point.face = item.face_tag;

  assign query.pos_x    = item.pos_x;
  assign query.pos_y    = item.pos_y;
  assign query.face_tag = item.face_tag;

  npfs_ram #(
    .WIDTH ($bits(npfs_point_t)),
    .DEPTH (MAX_POINTS)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(item.entry_index)),
    .wdata (wr_point),
    .re    (scan_rd_en),
    .raddr (scan_rd_addr),
    .rdata (rd_data)
  );

  npfs_scan #(
    .MAX_POINTS (MAX_POINTS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .query   (query),
    .count   (count),
    .rd_en   (scan_rd_en),
    .rd_addr (scan_rd_addr),
    .rd_data (rd_data),
    .done    (scan_done),
    .result  (scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      active_points <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_points <= cfg_wdata;
      end
      if (result_valid && result_ready && !out_load) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (scan_start) begin
            state <= T_BUSY;
          end
        end
        T_BUSY: begin
          if (scan_done) begin
            if (out_free) begin
              result       <= scan_result;
              result_valid <= 1'b1;
              state        <= T_IDLE;
            end else begin
              state <= T_HOLD;
            end
          end
        end
        T_HOLD: begin
          // scan result stays put until the next start
          if (out_free) begin
            result       <= scan_result;
            result_valid <= 1'b1;
            state        <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    scan_start |=> !item_ready)
    else $error("query accepted but block still ready");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == T_IDLE)
    else $error("table write while busy");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |->
      result.nearest_index == '0 && result.nearest_dist_sq == '0)
    else $error("not-found result carries nonzero fields");

  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> state == T_BUSY)
    else $error("scan finished while not busy");
`endif

endmodule

>>> rtl/npfs_ram.sv
module npfs_ram #(
  parameter int WIDTH  = 35,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/npfs_scan.sv
module npfs_scan
  import npfs_pkg::*;
#(
  parameter int MAX_POINTS = 512,
  parameter int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  parameter int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  npfs_query_t  query,
  input  logic [CW-1:0] count,
  output logic         rd_en,
  output logic [AW-1:0] rd_addr,
  input  npfs_point_t  rd_data,
  output logic         done,
  output npfs_result_t result
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN} state_t;

  state_t             state;
  npfs_query_t        q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      rd_cnt;
  logic [CW-1:0]      rd_cnt_next;

  // stage 1: memory data valid; stage 2: abs diffs; stage 3: squares
  logic               v1, v2, v3;
  logic [AW-1:0]      idx1, idx2, idx3;
  logic               match2, match3;
  logic [COORD_W-1:0] dx, dy;
  logic [COORD_W-1:0] dx_next, dy_next;
  logic [2*COORD_W-1:0] sqx, sqy;
  logic [DIST_W-1:0]  dsum;

  logic               hit;
  logic [AW-1:0]      best_idx;
  logic [DIST_W-1:0]  best;

  assign rd_cnt_next = rd_cnt + 1'b1;
  assign rd_en       = (state == S_ISSUE);
  assign rd_addr     = rd_cnt[AW-1:0];

  assign dx_next = (rd_data.x >= q.pos_x) ? rd_data.x - q.pos_x : q.pos_x - rd_data.x;
  assign dy_next = (rd_data.y >= q.pos_y) ? rd_data.y - q.pos_y : q.pos_y - rd_data.y;
  assign dsum    = {1'b0, sqx} + {1'b0, sqy};

  assign done = (state == S_DRAIN) && !v1 && !v2 && !v3;

  assign result.found           = hit;
  assign result.nearest_index   = hit ? IDX_W'(best_idx) : '0;
  assign result.nearest_dist_sq = hit ? best : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      hit   <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      v3 <= v2;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            q       <= query;
            count_q <= count;
            rd_cnt  <= '0;
            hit     <= 1'b0;
            state   <= (count == '0) ? S_DRAIN : S_ISSUE;
          end
        end
        S_ISSUE: begin
          rd_cnt <= rd_cnt_next;
          if (rd_cnt_next == count_q) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // strict less-than keeps the first minimum in table order
      if (v3 && match3 && (!hit || dsum < best)) begin
        hit      <= 1'b1;
        best     <= dsum;
        best_idx <= idx3;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1   <= rd_cnt[AW-1:0];
    idx2   <= idx1;
    dx     <= dx_next;
    dy     <= dy_next;
    match2 <= (rd_data.face == q.face_tag);
    idx3   <= idx2;
    match3 <= match2;
    sqx    <= dx * dx;
    sqy    <= dy * dy;
  end

`ifndef NO_ASSERTIONS
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    start && state == S_IDLE |=> state != S_IDLE)
    else $error("scan did not start");

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ISSUE |-> rd_cnt < count_q)
    else $error("read beyond active count");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    hit && state != S_IDLE |-> CW'(best_idx) < count_q)
    else $error("best index beyond active count");

  a_pipe_only_busy: assert property (@(posedge clk) disable iff (rst)
    v1 || v2 || v3 |-> state != S_IDLE)
    else $error("pipeline active while idle");
`endif

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import npfs_pkg::*;

  localparam int TABLE_DEPTH = 512;
  localparam int HOLD_CYCLES = 300;

  // Mirror of the point table plus the search; expected answers queue in order.
  class face_search_board;
    npfs_point_t        pts [TABLE_DEPTH];
    logic [COUNT_W-1:0] active_cnt = '0;
    npfs_result_t       pending_answers [$];
    int                 mismatches = 0;

    function void complain(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void apply_item(npfs_item_t it);
      int                n;
      bit                hit;
      int                best_i;
      longint unsigned   dx, dy, d, best;
      npfs_result_t      r;
      if (it.cmd == CMD_WRITE) begin
        pts[it.entry_index] = '{x: it.pos_x, y: it.pos_y, face: it.face_tag};
        return;
      end
      n = (active_cnt > TABLE_DEPTH) ? TABLE_DEPTH : active_cnt;
      hit = 0;
      best_i = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
        if (pts[i].face != it.face_tag) continue;
        dx = (pts[i].x >= it.pos_x) ? pts[i].x - it.pos_x : it.pos_x - pts[i].x;
        dy = (pts[i].y >= it.pos_y) ? pts[i].y - it.pos_y : it.pos_y - pts[i].y;
        d = dx * dx + dy * dy;
        // strict less-than keeps the lowest index on ties
        if (!hit || d < best) begin
          hit = 1;
          best = d;
          best_i = i;
        end
      end
      r.found = hit;
      r.nearest_index = hit ? best_i[IDX_W-1:0] : '0;
      r.nearest_dist_sq = hit ? best[DIST_W-1:0] : '0;
      pending_answers.push_back(r);
    endfunction

    function void check_result(npfs_result_t got);
      npfs_result_t want;
      if (pending_answers.size() == 0) begin
        complain($sformatf("unexpected result: found=%0d idx=%0d dist=%0d",
                           got.found, got.nearest_index, got.nearest_dist_sq));
        return;
      end
      want = pending_answers.pop_front();
      if (got.found !== want.found || got.nearest_index !== want.nearest_index ||
          got.nearest_dist_sq !== want.nearest_dist_sq)
        complain($sformatf({"mismatch: expected found=%0d idx=%0d dist=%0d, ",
                            "got found=%0d idx=%0d dist=%0d"},
                           want.found, want.nearest_index, want.nearest_dist_sq,
                           got.found, got.nearest_index, got.nearest_dist_sq));
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction

    function void wrap_up();
      if (pending_answers.size() != 0)
        complain($sformatf("%0d expected results never arrived", pending_answers.size()));
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               item_valid = 0;
  logic               item_ready;
  npfs_item_t         item = '0;
  logic               result_valid;
  logic               result_ready = 0;
  npfs_result_t       result;

  face_search_board   board = new;
  bit                 loaded [TABLE_DEPTH];
  bit                 gaps_on = 1;
  bit                 hold_req = 0;

  nearest_point_on_face_search #(.MAX_POINTS(TABLE_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #6000000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) board.apply_item(item);
      if (result_valid && result_ready) board.check_result(result);
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      if (hold_req) begin
        result_ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        result_ready <= 0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        result_ready <= 1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // number of entries written contiguously from index 0
  function automatic int prefix_len();
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (!loaded[i]) return i;
    return TABLE_DEPTH;
  endfunction

  function automatic npfs_item_t mk(logic c, int idx, int x, int y, int f);
    return '{cmd: c, entry_index: IDX_W'(idx), pos_x: COORD_W'(x), pos_y: COORD_W'(y),
             face_tag: FACE_W'(f)};
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  function automatic npfs_item_t rand_item(int act);
    npfs_item_t it;
    int         n, j, span;
    it.entry_index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    it.pos_x = COORD_W'($urandom);
    it.pos_y = COORD_W'($urandom);
    it.face_tag = FACE_W'($urandom_range(0, 7));
    n = (act > TABLE_DEPTH) ? TABLE_DEPTH : act;
    if ($urandom_range(0, 9) < 4) begin
      it.cmd = CMD_WRITE;
      // keep writes near the written prefix so it grows
      span = prefix_len() + 4;
      if (span > TABLE_DEPTH) span = TABLE_DEPTH;
      it.entry_index = IDX_W'($urandom_range(0, span - 1));
      if ($urandom_range(0, 3) != 0) it.face_tag = FACE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: begin
          it.pos_x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          it.pos_y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        1: begin
          it.pos_x = COORD_W'(16'h4000 + $urandom_range(0, 255));
          it.pos_y = COORD_W'(16'h4000 + $urandom_range(0, 255));
        end
        default: ;
      endcase
    end else begin
      it.cmd = CMD_QUERY;
      if (n > 0 && $urandom_range(0, 2) != 0) begin
        j = $urandom_range(0, n - 1);
        it.face_tag = board.pts[j].face;
        if ($urandom_range(0, 3) == 0) begin
          it.pos_x = board.pts[j].x;
          it.pos_y = board.pts[j].y;
        end else begin
          it.pos_x = COORD_W'(clamp_coord(int'(board.pts[j].x)
                                          + int'($urandom_range(0, 64)) - 32));
          it.pos_y = COORD_W'(clamp_coord(int'(board.pts[j].y)
                                          + int'($urandom_range(0, 64)) - 32));
        end
      end
    end
    return it;
  endfunction

  task automatic send_item(input npfs_item_t it);
    item <= it;
    item_valid <= 1;
    if (it.cmd == CMD_WRITE) loaded[it.entry_index] = 1;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // wait until every query has answered and the block has gone quiet
  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_active(input int v);
    cfg_we <= 1;
    cfg_wdata <= v[COUNT_W-1:0];
    board.active_cnt = v[COUNT_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int act, input int n_items, input bit long_hold);
    drain();
    set_active(act);
    if (long_hold) hold_req = 1;
    for (int k = 0; k < n_items; k++) begin
      sender_gap();
      send_item(rand_item(act));
    end
  endtask

  task automatic fill_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!loaded[i]) begin
        sender_gap();
        send_item(mk(CMD_WRITE, i, int'($urandom_range(0, 65535)),
                     int'($urandom_range(0, 65535)), int'($urandom_range(0, 7))));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // empty table, first at the reset count and then with zero written
    send_item(mk(CMD_QUERY, 5, 0, 0, 0));
    drain();
    set_active(0);
    send_item(mk(CMD_QUERY, 511, 65535, 65535, 7));

    send_item(mk(CMD_WRITE, 0, 0, 0, 0));
    send_item(mk(CMD_WRITE, 1, 65535, 65535, 0));
    send_item(mk(CMD_WRITE, 2, 65535, 0, 7));
    send_item(mk(CMD_WRITE, 3, 100, 100, 2));
    send_item(mk(CMD_WRITE, 4, 110, 100, 2));
    send_item(mk(CMD_WRITE, 5, 0, 65535, 5));
    send_item(mk(CMD_WRITE, 6, 100, 100, 2));
    send_item(mk(CMD_WRITE, 7, 12345, 54321, 3));
    drain();
    set_active(8);
    send_item(mk(CMD_QUERY, 0, 0, 0, 0));
    send_item(mk(CMD_QUERY, 0, 65535, 65535, 0));
    send_item(mk(CMD_QUERY, 3, 65535, 65535, 5));
    send_item(mk(CMD_QUERY, 0, 0, 65535, 7));        // largest possible distance
    send_item(mk(CMD_QUERY, 0, 105, 100, 2));        // equal distance to three entries
    send_item(mk(CMD_QUERY, 0, 100, 100, 2));        // duplicate point, lower index wins
    send_item(mk(CMD_QUERY, 0, 12345, 54321, 1));    // face not in table
    send_item(mk(CMD_QUERY, 0, 0, 0, 6));
    send_item(mk(CMD_QUERY, 0, 65535, 0, 3));

    run_phase(1, 8, 0);
    run_phase(prefix_len(), 16, 1);
    repeat (2) run_phase($urandom_range(1, prefix_len()), 12, 0);
    fill_table();
    run_phase(TABLE_DEPTH, 10, 0);
    run_phase(1023, 6, 0);                           // count above table size saturates
    run_phase(TABLE_DEPTH + 1, 4, 0);
    run_phase(0, 4, 0);
    drain();
    gaps_on = 0;
    run_phase($urandom_range(1, 64), 16, 0);

    drain();
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    board.wrap_up();
    if (board.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
rtl/npfs_pkg.sv
rtl/npfs_ram.sv
rtl/npfs_scan.sv
rtl/nearest_point_on_face_search.sv
tb/sv/tb_top.sv
